>>> design/sramp_pkg.sv
// Shared types and constants of the speed ramp with emergency stop.
// Used by every module of the block except sramp_queue; no dependencies.
package sramp_pkg;

  localparam int SPEED_BITS_DEF = 11;
  localparam int POWER_BITS_DEF = 10;
  localparam int STEP_W         = 10;
  localparam int IVL_W          = 16;
  localparam int CFG_DATA_W     = 16;
  localparam int CFG_IDX_W      = 3;
  localparam int QUEUE_DEPTH    = 2;

  localparam logic [STEP_W-1:0] ACCEL_RST = 10'd1;
  localparam logic [STEP_W-1:0] BRAKE_RST = 10'd1;
  localparam logic [IVL_W-1:0]  IVL_RST   = 16'd100;

  typedef enum logic [1:0] {
    OP_TICK    = 2'd0,
    OP_SET     = 2'd1,
    OP_ESTOP   = 2'd2,
    OP_RELEASE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    EV_NONE = 2'd0,
    EV_STOP = 2'd1,
    EV_FWD  = 2'd2,
    EV_REV  = 2'd3
  } light_ev_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ACCEL   = 3'd0,
    REG_BRAKE   = 3'd1,
    REG_IVL     = 3'd2,
    REG_MIN_PWR = 3'd3,
    REG_MAX_PWR = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic tick;
    logic set_goal;
    logic estop;
    logic rel;
  } cmd_kind_t;

endpackage

>>> design/speed_ramp_with_estop.sv
// Top level of the motor speed ramp with emergency stop.
// Instantiates sramp_front, sramp_queue, sramp_back and sramp_pmap; uses sramp_pkg.
//
//   port group  direction  handshake            payload
//   in          input      in_valid / in_stall  in_op, in_target_speed, in_max_speed
//   out         output     out_valid / out_stall  out_speed, out_drive_power,
//                                               out_light_event, out_speed_changed
//   cfg         input      cfg_we               cfg_idx, cfg_wdata
//
// An item that moves the speed to a non-zero value holds the back stage in ST_CALC until
// the power mapper, with its two-bit-per-cycle divider, is done; any other item goes
// from ST_IDLE straight to ST_OUT.
// The front register and a two-entry queue keep taking beats while the back stage works.
// rst_n is synchronous and active low; config resets to step 1/1, interval 100,
// power span 0 to full scale. A stalled result holds the back stage in place.
module speed_ramp_with_estop #(
  parameter int SPEED_BITS = sramp_pkg::SPEED_BITS_DEF,
  parameter int POWER_BITS = sramp_pkg::POWER_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       in_op,
  input  logic signed [SPEED_BITS-1:0]     in_target_speed,
  input  logic [SPEED_BITS-2:0]            in_max_speed,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [SPEED_BITS-1:0]     out_speed,
  output logic signed [POWER_BITS:0]       out_drive_power,
  output logic [1:0]                       out_light_event,
  output logic                             out_speed_changed,
  input  logic                             cfg_we,
  input  logic [sramp_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [sramp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int KW = $bits(sramp_pkg::cmd_kind_t);
  localparam int QW = KW + 2 * SPEED_BITS - 1;

  logic                         q_push;
  logic                         q_full;
  logic                         q_pop;
  logic                         q_vld;
  logic [QW-1:0]                q_din;
  logic [QW-1:0]                q_dout;
  sramp_pkg::cmd_kind_t         f_kind;
  logic signed [SPEED_BITS-1:0] f_target;
  logic [SPEED_BITS-2:0]        f_fs;
  sramp_pkg::cmd_kind_t         b_kind;
  logic signed [SPEED_BITS-1:0] b_target;
  logic [SPEED_BITS-2:0]        b_fs;
  logic                         pm_start;
  logic signed [SPEED_BITS-1:0] pm_speed;
  logic [SPEED_BITS-2:0]        pm_fs;
  logic [POWER_BITS-1:0]        pm_min;
  logic [POWER_BITS-1:0]        pm_max;
  logic                         pm_done;
  logic [POWER_BITS-1:0]        pm_level;

  sramp_front #(
    .SPEED_BITS (SPEED_BITS)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_op           (in_op),
    .in_target_speed (in_target_speed),
    .in_max_speed    (in_max_speed),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_kind          (f_kind),
    .q_target        (f_target),
    .q_fs            (f_fs)
  );

  assign q_din = {f_kind, f_target, f_fs};

  sramp_queue #(
    .W     (QW),
    .DEPTH (sramp_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (q_push),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .dout  (q_dout),
    .vld   (q_vld)
  );

  assign b_kind   = sramp_pkg::cmd_kind_t'(q_dout[QW-1 -: KW]);
  assign b_target = q_dout[2*SPEED_BITS-2 -: SPEED_BITS];
  assign b_fs     = q_dout[SPEED_BITS-2:0];

  sramp_back #(
    .SPEED_BITS (SPEED_BITS),
    .POWER_BITS (POWER_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_idx           (cfg_idx),
    .cfg_wdata         (cfg_wdata),
    .q_vld             (q_vld),
    .q_pop             (q_pop),
    .q_kind            (b_kind),
    .q_target          (b_target),
    .q_fs              (b_fs),
    .pm_start          (pm_start),
    .pm_speed          (pm_speed),
    .pm_fs             (pm_fs),
    .pm_min            (pm_min),
    .pm_max            (pm_max),
    .pm_done           (pm_done),
    .pm_level          (pm_level),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_speed         (out_speed),
    .out_drive_power   (out_drive_power),
    .out_light_event   (out_light_event),
    .out_speed_changed (out_speed_changed)
  );

  sramp_pmap #(
    .SPEED_BITS (SPEED_BITS),
    .POWER_BITS (POWER_BITS)
  ) u_pmap (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (pm_start),
    .speed   (pm_speed),
    .fs      (pm_fs),
    .min_pwr (pm_min),
    .max_pwr (pm_max),
    .done    (pm_done),
    .level   (pm_level)
  );

endmodule

>>> design/sramp_front.sv
// Front stage: accepts input beats, classifies the op into a command kind
// and pushes the command into the queue. Depends on sramp_pkg.
module sramp_front #(
  parameter int SPEED_BITS = sramp_pkg::SPEED_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   in_op,
  input  logic signed [SPEED_BITS-1:0] in_target_speed,
  input  logic [SPEED_BITS-2:0]        in_max_speed,
  input  logic                         q_full,
  output logic                         q_push,
  output sramp_pkg::cmd_kind_t         q_kind,
  output logic signed [SPEED_BITS-1:0] q_target,
  output logic [SPEED_BITS-2:0]        q_fs
);

  logic                         slot_vld_r;
  logic                         slot_vld_nxt;
  logic                         accept;
  sramp_pkg::cmd_kind_t         kind_nxt;
  sramp_pkg::cmd_kind_t         kind_r;
  logic signed [SPEED_BITS-1:0] tgt_r;
  logic [SPEED_BITS-2:0]        fs_r;

  assign in_stall     = slot_vld_r & q_full;
  assign accept       = in_valid & ~in_stall;
  assign q_push       = slot_vld_r & ~q_full;
  assign slot_vld_nxt = accept | (slot_vld_r & ~q_push);

  always_comb begin
    kind_nxt = '0;
    case (sramp_pkg::op_t'(in_op))
      sramp_pkg::OP_TICK:    kind_nxt.tick     = 1'b1;
      sramp_pkg::OP_SET:     kind_nxt.set_goal = 1'b1;
      sramp_pkg::OP_ESTOP:   kind_nxt.estop    = 1'b1;
      sramp_pkg::OP_RELEASE: kind_nxt.rel      = 1'b1;
      default:               kind_nxt          = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= 1'b0;
    end else begin
      slot_vld_r <= slot_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r <= kind_nxt;
      tgt_r  <= in_target_speed;
      fs_r   <= in_max_speed;
    end
  end

  assign q_kind   = kind_r;
  assign q_target = tgt_r;
  assign q_fs     = fs_r;

endmodule

>>> design/sramp_queue.sv
// Short command queue between front and back stages.
// Generic over width and power-of-two depth; depends on nothing.
module sramp_queue #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] din,
  output logic         full,
  input  logic         pop,
  output logic [W-1:0] dout,
  output logic         vld
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wr_ptr_r;
  logic [AW-1:0] rd_ptr_r;
  logic [AW:0]   cnt_r;
  logic [AW:0]   cnt_nxt;

  assign full = (cnt_r == (AW + 1)'(DEPTH));
  assign vld  = (cnt_r != '0);
  assign dout = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= din;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r < (AW + 1)'(DEPTH)))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("queue pop while empty");

endmodule

>>> design/sramp_pmap.sv
// Power mapper: level = min + |speed| * (max - min) / full_scale, clamped.
// A multiply state, then a restoring divider retiring two bits a cycle.
// Depends on sramp_pkg for width defaults.
module sramp_pmap #(
  parameter int SPEED_BITS = sramp_pkg::SPEED_BITS_DEF,
  parameter int POWER_BITS = sramp_pkg::POWER_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  input  logic signed [SPEED_BITS-1:0] speed,
  input  logic [SPEED_BITS-2:0]        fs,
  input  logic [POWER_BITS-1:0]        min_pwr,
  input  logic [POWER_BITS-1:0]        max_pwr,
  output logic                         done,
  output logic [POWER_BITS-1:0]        level
);

  localparam int SB   = SPEED_BITS;
  localparam int PB   = POWER_BITS;
  localparam int PW   = SB + PB;
  localparam int ITER = (PW + 1) / 2;
  localparam int DW   = 2 * ITER;
  localparam int CW   = $clog2(ITER + 1);

  typedef enum logic [3:0] {
    PM_IDLE = 4'b0001,
    PM_MUL  = 4'b0010,
    PM_DIV  = 4'b0100,
    PM_FIN  = 4'b1000
  } pm_state_t;

  pm_state_t       state_r;
  pm_state_t       state_nxt;
  logic [SB-1:0]   mag_r;
  logic [PB-1:0]   dmag_r;
  logic            dneg_r;
  logic [SB-2:0]   fs_r;
  logic [PB-1:0]   min_r;
  logic [PB-1:0]   max_r;
  logic [DW-1:0]   num_r;
  logic [SB-2:0]   rem_r;
  logic [CW-1:0]   cnt_r;
  logic            done_r;
  logic [PB-1:0]   level_r;
  logic [PW-1:0]   prod;
  logic [DW-1:0]   num_step;
  logic [SB-2:0]   rem_step;
  logic [SB-1:0]   mag_in;
  logic            big;
  logic [PB-1:0]   level_sel;

  assign mag_in = speed[SB-1] ? (~speed + 1'b1) : speed;
  assign prod   = mag_r * dmag_r;

  always_comb begin
    logic [SB-2:0] r;
    logic [DW-1:0] n;
    logic [SB-1:0] r_ext;
    r     = rem_r;
    n     = num_r;
    r_ext = '0;
    for (int k = 0; k < 2; k++) begin
      r_ext = {r, n[DW-1]};
      n     = {n[DW-2:0], 1'b0};
      if (r_ext >= {1'b0, fs_r}) begin
        r_ext = r_ext - {1'b0, fs_r};
        n[0]  = 1'b1;
      end
      r = r_ext[SB-2:0];
    end
    rem_step = r;
    num_step = n;
  end

  assign big       = (fs_r == '0) || (num_r >= DW'(dmag_r));
  assign level_sel = big    ? max_r :
                     dneg_r ? (min_r - num_r[PB-1:0]) : (min_r + num_r[PB-1:0]);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      PM_IDLE: if (start) state_nxt = PM_MUL;
      PM_MUL:  state_nxt = PM_DIV;
      PM_DIV:  if (cnt_r == CW'(1)) state_nxt = PM_FIN;
      PM_FIN:  state_nxt = PM_IDLE;
      default: state_nxt = PM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PM_IDLE;
      done_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      done_r  <= (state_r == PM_FIN);
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      PM_IDLE: begin
        if (start) begin
          mag_r  <= mag_in;
          dneg_r <= (max_pwr < min_pwr);
          dmag_r <= (max_pwr < min_pwr) ? (min_pwr - max_pwr) : (max_pwr - min_pwr);
          fs_r   <= fs;
          min_r  <= min_pwr;
          max_r  <= max_pwr;
        end
      end
      PM_MUL: begin
        num_r <= DW'(prod);
        rem_r <= '0;
        cnt_r <= CW'(ITER);
      end
      PM_DIV: begin
        num_r <= num_step;
        rem_r <= rem_step;
        cnt_r <= cnt_r - 1'b1;
      end
      PM_FIN: begin
        level_r <= level_sel;
      end
      default: ;
    endcase
  end

  assign done  = done_r;
  assign level = level_r;

endmodule

>>> design/sramp_back.sv
// Back stage: configuration registers, ramp state and the ramp rule,
// sequencing of the power mapper and the output register.
// Depends on sramp_pkg.
module sramp_back #(
  parameter int SPEED_BITS = sramp_pkg::SPEED_BITS_DEF,
  parameter int POWER_BITS = sramp_pkg::POWER_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [sramp_pkg::CFG_IDX_W-1:0]     cfg_idx,
  input  logic [sramp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
  input  logic                                q_vld,
  output logic                                q_pop,
  input  sramp_pkg::cmd_kind_t                q_kind,
  input  logic signed [SPEED_BITS-1:0]        q_target,
  input  logic [SPEED_BITS-2:0]               q_fs,
  output logic                                pm_start,
  output logic signed [SPEED_BITS-1:0]        pm_speed,
  output logic [SPEED_BITS-2:0]               pm_fs,
  output logic [POWER_BITS-1:0]               pm_min,
  output logic [POWER_BITS-1:0]               pm_max,
  input  logic                                pm_done,
  input  logic [POWER_BITS-1:0]               pm_level,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [SPEED_BITS-1:0]        out_speed,
  output logic signed [POWER_BITS:0]          out_drive_power,
  output logic [1:0]                          out_light_event,
  output logic                                out_speed_changed
);

  localparam int SB = SPEED_BITS;
  localparam int PB = POWER_BITS;
  localparam int SW = sramp_pkg::STEP_W;
  localparam int IW = sramp_pkg::IVL_W;
  localparam int AW = ((SB > SW) ? SB : SW) + 2;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CALC = 3'b010,
    ST_OUT  = 3'b100
  } bk_state_t;

  bk_state_t                state_r;
  bk_state_t                state_nxt;
  logic [SW-1:0]            accel_r;
  logic [SW-1:0]            brake_r;
  logic [IW-1:0]            ivl_r;
  logic [PB-1:0]            minp_r;
  logic [PB-1:0]            maxp_r;
  logic signed [SB-1:0]     cur_r;
  logic signed [SB-1:0]     goal_r;
  logic [SB-2:0]            fs_r;
  logic                     estop_r;
  logic [IW-1:0]            ms_r;
  logic                     start_r;
  logic                     res_chg_r;
  sramp_pkg::light_ev_t     res_ev_r;
  logic signed [PB:0]       res_pwr_r;
  logic                     out_vld_r;
  logic                     out_vld_nxt;
  logic signed [SB-1:0]     out_speed_r;
  logic signed [PB:0]       out_pwr_r;
  sramp_pkg::light_ev_t     out_ev_r;
  logic                     out_chg_r;

  logic [IW-1:0]            ms_n;
  logic [IW-1:0]            ms_c;
  logic signed [SB-1:0]     goal_n;
  logic [SB-2:0]            fs_n;
  logic                     estop_n;
  logic signed [AW-1:0]     cur_x;
  logic signed [AW-1:0]     goal_x;
  logic signed [AW-1:0]     mag_c;
  logic signed [AW-1:0]     mag_g;
  logic signed [AW-1:0]     st_x;
  logic signed [AW-1:0]     nx;
  logic                     grow;
  logic [SW-1:0]            st;
  logic                     chg;
  logic signed [SB-1:0]     ns;
  sramp_pkg::light_ev_t     ev;
  logic                     pm_need;
  logic                     out_load;
  logic signed [PB:0]       lvl_x;

  // config writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r <= sramp_pkg::ACCEL_RST;
      brake_r <= sramp_pkg::BRAKE_RST;
      ivl_r   <= sramp_pkg::IVL_RST;
      minp_r  <= '0;
      maxp_r  <= '1;
    end else if (cfg_we) begin
      case (sramp_pkg::cfg_reg_t'(cfg_idx))
        sramp_pkg::REG_ACCEL:   accel_r <= cfg_wdata[SW-1:0];
        sramp_pkg::REG_BRAKE:   brake_r <= cfg_wdata[SW-1:0];
        sramp_pkg::REG_IVL:     ivl_r   <= cfg_wdata[IW-1:0];
        sramp_pkg::REG_MIN_PWR: minp_r  <= cfg_wdata[PB-1:0];
        sramp_pkg::REG_MAX_PWR: maxp_r  <= cfg_wdata[PB-1:0];
        default: ;
      endcase
    end
  end

  // ramp rule on the command at the head of the queue
  always_comb begin
    ms_n    = (q_kind.tick && (ms_r != '1)) ? (ms_r + 1'b1) : ms_r;
    goal_n  = q_kind.set_goal ? q_target : goal_r;
    fs_n    = q_kind.set_goal ? q_fs : fs_r;
    estop_n = q_kind.estop ? 1'b1 : (q_kind.rel ? 1'b0 : estop_r);

    cur_x  = AW'(cur_r);
    goal_x = AW'(goal_n);
    mag_c  = (cur_x < 0) ? -cur_x : cur_x;
    mag_g  = (goal_x < 0) ? -goal_x : goal_x;
    grow   = (mag_c < mag_g) && (((cur_x > 0) && (goal_x > 0)) ||
                                 ((cur_x < 0) && (goal_x < 0)));
    st     = grow ? accel_r : brake_r;
    st_x   = AW'($signed({1'b0, st}));
    if (cur_x < goal_x) begin
      nx = cur_x + st_x;
      if (nx > goal_x) nx = goal_x;
    end else begin
      nx = cur_x - st_x;
      if (nx < goal_x) nx = goal_x;
    end

    chg  = 1'b0;
    ms_c = ms_n;
    ns   = cur_r;
    if (estop_n) begin
      if (cur_r != 0) begin
        chg = 1'b1;
        ns  = '0;
      end
    end else if (cur_r != goal_n) begin
      if (goal_n == 0) begin
        chg = 1'b1;
        ns  = '0;
      end else if (ms_n >= ivl_r) begin
        chg  = 1'b1;
        ms_c = '0;
        ns   = nx[SB-1:0];
      end
    end

    if (!chg) begin
      ev = sramp_pkg::EV_NONE;
    end else if ((ns == 0) && (cur_r != 0)) begin
      ev = sramp_pkg::EV_STOP;
    end else if ((ns > 0) && (cur_r <= 0)) begin
      ev = sramp_pkg::EV_FWD;
    end else if ((ns < 0) && (cur_r >= 0)) begin
      ev = sramp_pkg::EV_REV;
    end else begin
      ev = sramp_pkg::EV_NONE;
    end
  end

  assign pm_need  = chg && (ns != 0);
  assign q_pop    = (state_r == ST_IDLE) && q_vld;
  assign out_load = (state_r == ST_OUT) && (!out_vld_r || !out_stall);
  assign lvl_x    = $signed({1'b0, pm_level});

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (q_vld) state_nxt = pm_need ? ST_CALC : ST_OUT;
      ST_CALC: if (pm_done) state_nxt = ST_OUT;
      ST_OUT:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_load) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      cur_r     <= '0;
      goal_r    <= '0;
      fs_r      <= '0;
      estop_r   <= 1'b0;
      ms_r      <= '0;
      start_r   <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      start_r   <= q_pop && pm_need;
      out_vld_r <= out_vld_nxt;
      if (q_pop) begin
        cur_r   <= ns;
        goal_r  <= goal_n;
        fs_r    <= fs_n;
        estop_r <= estop_n;
        ms_r    <= ms_c;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      res_chg_r <= chg;
      res_ev_r  <= ev;
      res_pwr_r <= '0;
    end else if ((state_r == ST_CALC) && pm_done) begin
      res_pwr_r <= cur_r[SB-1] ? -lvl_x : lvl_x;
    end
    if (out_load) begin
      out_speed_r <= cur_r;
      out_pwr_r   <= res_pwr_r;
      out_ev_r    <= res_ev_r;
      out_chg_r   <= res_chg_r;
    end
  end

  assign pm_start          = start_r;
  assign pm_speed          = cur_r;
  assign pm_fs             = fs_r;
  assign pm_min            = minp_r;
  assign pm_max            = maxp_r;
  assign out_valid         = out_vld_r;
  assign out_speed         = out_speed_r;
  assign out_drive_power   = out_pwr_r;
  assign out_light_event   = out_ev_r;
  assign out_speed_changed = out_chg_r;

  a_estop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    estop_r |-> (cur_r == 0))
    else $error("speed not zero under emergency stop");

  a_done_in_calc: assert property (@(posedge clk) disable iff (!rst_n)
    pm_done |-> (state_r == ST_CALC))
    else $error("power mapper finished with no item waiting");

  a_quiet_result: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_OUT) && !res_chg_r) |->
      ((res_pwr_r == 0) && (res_ev_r == sramp_pkg::EV_NONE)))
    else $error("unchanged result carries power or event");

endmodule

>>> tb/speed_ramp_checker.sv
`timescale 1ns / 1ps
// Scoreboard for speed_ramp_with_estop: follows register writes, predicts one
// result beat per accepted input beat and compares results in order.
// Depends on sramp_pkg.
module speed_ramp_checker #(
  parameter int SB = sramp_pkg::SPEED_BITS_DEF,
  parameter int PB = sramp_pkg::POWER_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [1:0]                       in_op,
  input  logic signed [SB-1:0]             in_target_speed,
  input  logic [SB-2:0]                    in_max_speed,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic signed [SB-1:0]             out_speed,
  input  logic signed [PB:0]               out_drive_power,
  input  logic [1:0]                       out_light_event,
  input  logic                             out_speed_changed,
  input  logic                             cfg_we,
  input  logic [sramp_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [sramp_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                               fail_count,
  output int                               pending_count,
  output int                               result_count
);

  typedef struct {
    logic signed [SB-1:0]  speed;
    logic signed [PB:0]    power;
    sramp_pkg::light_ev_t  ev;
    logic                  changed;
  } ramp_beat_t;

  logic [sramp_pkg::STEP_W-1:0] accel_step_r;
  logic [sramp_pkg::STEP_W-1:0] brake_step_r;
  logic [sramp_pkg::IVL_W-1:0]  step_ivl;
  logic [PB-1:0]                min_pwr;
  logic [PB-1:0]                max_pwr;

  logic signed [SB-1:0]         cur_speed;
  logic signed [SB-1:0]         goal_speed;
  logic [SB-2:0]                full_scale;
  logic                         estop_on;
  logic [sramp_pkg::IVL_W-1:0]  ms_count;

  ramp_beat_t                   expected_beats[$];

  function automatic ramp_beat_t land_speed(int ns);
    ramp_beat_t r;
    int old, mag, lvl, lo, hi;
    old = cur_speed;
    r.changed = 1'b1;
    if (ns == 0 && old != 0) r.ev = sramp_pkg::EV_STOP;
    else if (ns > 0 && old <= 0) r.ev = sramp_pkg::EV_FWD;
    else if (ns < 0 && old >= 0) r.ev = sramp_pkg::EV_REV;
    else r.ev = sramp_pkg::EV_NONE;
    cur_speed = ns[SB-1:0];
    mag = ns < 0 ? -ns : ns;
    lvl = 0;
    if (ns != 0) begin
      if (full_scale == 0) lvl = int'(max_pwr);
      else lvl = mag * (int'(max_pwr) - int'(min_pwr)) / int'(full_scale) + int'(min_pwr);
      lo = min_pwr < max_pwr ? int'(min_pwr) : int'(max_pwr);
      hi = min_pwr < max_pwr ? int'(max_pwr) : int'(min_pwr);
      if (lvl < lo) lvl = lo;
      if (lvl > hi) lvl = hi;
    end
    r.power = (PB+1)'(ns < 0 ? -lvl : lvl);
    r.speed = cur_speed;
    return r;
  endfunction

  function automatic ramp_beat_t advance_ramp(sramp_pkg::op_t op,
                                              logic signed [SB-1:0] tgt,
                                              logic [SB-2:0] full);
    ramp_beat_t r;
    int cur, goal, nxt, stp, cur_mag, goal_mag;
    logic grow;
    r.speed   = cur_speed;
    r.power   = '0;
    r.ev      = sramp_pkg::EV_NONE;
    r.changed = 1'b0;
    case (op)
      sramp_pkg::OP_TICK: begin
        if (ms_count != '1) ms_count = ms_count + 1'b1;
      end
      sramp_pkg::OP_SET: begin
        goal_speed = tgt;
        full_scale = full;
      end
      sramp_pkg::OP_ESTOP: estop_on = 1'b1;
      default: estop_on = 1'b0;
    endcase
    cur  = cur_speed;
    goal = goal_speed;
    if (estop_on) begin
      if (cur != 0) r = land_speed(0);
    end else if (cur != goal) begin
      if (goal == 0) begin
        r = land_speed(0);
      end else if (ms_count >= step_ivl) begin
        cur_mag  = cur < 0 ? -cur : cur;
        goal_mag = goal < 0 ? -goal : goal;
        grow = cur_mag < goal_mag && ((cur > 0 && goal > 0) || (cur < 0 && goal < 0));
        stp = grow ? int'(accel_step_r) : int'(brake_step_r);
        ms_count = '0;
        if (cur < goal) begin
          nxt = cur + stp;
          if (nxt > goal) nxt = goal;
        end else begin
          nxt = cur - stp;
          if (nxt < goal) nxt = goal;
        end
        r = land_speed(nxt);
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    ramp_beat_t want;
    if (!rst_n) begin
      accel_step_r  = sramp_pkg::ACCEL_RST;
      brake_step_r  = sramp_pkg::BRAKE_RST;
      step_ivl      = sramp_pkg::IVL_RST;
      min_pwr       = '0;
      max_pwr       = '1;
      cur_speed     = '0;
      goal_speed    = '0;
      full_scale    = '0;
      estop_on      = 1'b0;
      ms_count      = '0;
      fail_count    = 0;
      result_count  = 0;
      expected_beats.delete();
    end else begin
      if (out_valid && !out_stall) begin
        result_count++;
        if (expected_beats.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("result beat %0d unexpected: speed %0d power %0d event %0d chg %0b",
                     result_count, out_speed, out_drive_power, out_light_event,
                     out_speed_changed);
        end else begin
          want = expected_beats.pop_front();
          if (out_speed !== want.speed || out_drive_power !== want.power ||
              out_light_event !== want.ev || out_speed_changed !== want.changed) begin
            fail_count++;
            if (fail_count <= 10) begin
              $display("result beat %0d: exp speed %0d power %0d event %0d chg %0b",
                       result_count, want.speed, want.power, want.ev, want.changed);
              $display("  got speed %0d power %0d event %0d chg %0b",
                       out_speed, out_drive_power, out_light_event, out_speed_changed);
            end
          end
        end
      end
      if (cfg_we) begin
        case (cfg_idx)
          sramp_pkg::REG_ACCEL:   accel_step_r = cfg_wdata[sramp_pkg::STEP_W-1:0];
          sramp_pkg::REG_BRAKE:   brake_step_r = cfg_wdata[sramp_pkg::STEP_W-1:0];
          sramp_pkg::REG_IVL:     step_ivl     = cfg_wdata[sramp_pkg::IVL_W-1:0];
          sramp_pkg::REG_MIN_PWR: min_pwr      = cfg_wdata[PB-1:0];
          sramp_pkg::REG_MAX_PWR: max_pwr      = cfg_wdata[PB-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        expected_beats.push_back(advance_ramp(sramp_pkg::op_t'(in_op), in_target_speed,
                                              in_max_speed));
    end
    pending_count = expected_beats.size();
  end

endmodule

>>> tb/tb_speed_ramp_with_estop.sv
`timescale 1ns / 1ps
// Top of the speed_ramp_with_estop testbench: clock, reset, register writes and
// input traffic with random stalls; checking lives in speed_ramp_checker.
// Depends on sramp_pkg, speed_ramp_with_estop and speed_ramp_checker.
module tb_speed_ramp_with_estop;

  localparam int SB               = sramp_pkg::SPEED_BITS_DEF;
  localparam int PB               = sramp_pkg::POWER_BITS_DEF;
  localparam int CW               = sramp_pkg::CFG_DATA_W;
  localparam int QUIET            = 40;
  localparam int HOLD_TICKS       = 20;
  localparam int RAND_PHASE_BEATS = 78;

  localparam logic [sramp_pkg::CFG_IDX_W-1:0] REG_SPARE = 3'd7;
  localparam logic signed [SB-1:0] SPD_MOST_NEG = {1'b1, {(SB-1){1'b0}}};
  localparam logic signed [SB-1:0] SPD_TOP      = {1'b0, {(SB-1){1'b1}}};
  localparam logic [SB-2:0]        FULL_TOP     = '1;
  localparam logic [PB-1:0]        PWR_TOP      = '1;
  localparam logic [sramp_pkg::STEP_W-1:0] STEP_TOP = '1;
  localparam logic [sramp_pkg::IVL_W-1:0]  IVL_TOP  = '1;

  logic                             clk;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_stall;
  sramp_pkg::op_t                   in_op;
  logic signed [SB-1:0]             in_target_speed;
  logic [SB-2:0]                    in_max_speed;
  logic                             out_valid;
  logic                             out_stall;
  logic signed [SB-1:0]             out_speed;
  logic signed [PB:0]               out_drive_power;
  logic [1:0]                       out_light_event;
  logic                             out_speed_changed;
  logic                             cfg_we;
  logic [sramp_pkg::CFG_IDX_W-1:0]  cfg_idx;
  logic [CW-1:0]                    cfg_wdata;

  int fail_count;
  int pending_count;
  int result_count;
  int beats_sent;
  int settings_count;
  bit idle_on;

  speed_ramp_with_estop #(.SPEED_BITS(SB), .POWER_BITS(PB)) dut (.*);

  speed_ramp_checker #(.SB(SB), .PB(PB)) u_check (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("speed_ramp_with_estop: mismatch");
    $finish;
  end

  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  task automatic send_beat(sramp_pkg::op_t op, logic signed [SB-1:0] tgt,
                           logic [SB-2:0] full);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(negedge clk);
    end
    in_valid        <= 1'b1;
    in_op           <= op;
    in_target_speed <= tgt;
    in_max_speed    <= full;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_tick();
    send_beat(sramp_pkg::OP_TICK, SB'($urandom), (SB-1)'($urandom));
  endtask

  task automatic write_reg(logic [sramp_pkg::CFG_IDX_W-1:0] idx, logic [CW-1:0] val);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= val;
    @(negedge clk);
  endtask

  // drain all pending results, then rewrite every register
  task automatic load_regs(logic [CW-1:0] accel, logic [CW-1:0] brake,
                           logic [CW-1:0] ivl, logic [CW-1:0] pmin,
                           logic [CW-1:0] pmax);
    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (QUIET) @(negedge clk);
    write_reg(sramp_pkg::REG_ACCEL, accel);
    write_reg(sramp_pkg::REG_BRAKE, brake);
    write_reg(sramp_pkg::REG_IVL, ivl);
    write_reg(sramp_pkg::REG_MIN_PWR, pmin);
    write_reg(sramp_pkg::REG_MAX_PWR, pmax);
    write_reg(REG_SPARE, CW'($urandom));
    cfg_we <= 1'b0;
    settings_count++;
  endtask

  function automatic logic signed [SB-1:0] pick_target();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return SPD_TOP;
      2:       return -SPD_TOP;
      3:       return SPD_MOST_NEG;
      4, 5:    return SB'($urandom_range(0, 80)) - SB'(40);
      default: return SB'($urandom);
    endcase
  endfunction

  function automatic logic [SB-2:0] pick_full();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return FULL_TOP;
      2, 3, 4: return (SB-1)'($urandom_range(1, 60));
      default: return (SB-1)'($urandom);
    endcase
  endfunction

  // mostly a new goal followed by ticks; some e-stop windows and stray ops
  task automatic run_traffic(int n);
    int stop_at, k;
    stop_at = beats_sent + n;
    while (beats_sent < stop_at) begin
      k = $urandom_range(0, 99);
      if (k < 70) begin
        send_beat(sramp_pkg::OP_SET, pick_target(), pick_full());
        repeat ($urandom_range(1, 10)) send_tick();
      end else if (k < 85) begin
        send_beat(sramp_pkg::OP_ESTOP, SB'($urandom), (SB-1)'($urandom));
        repeat ($urandom_range(0, 3)) send_tick();
        send_beat(sramp_pkg::OP_RELEASE, SB'($urandom), (SB-1)'($urandom));
      end else begin
        send_beat(sramp_pkg::op_t'($urandom_range(0, 3)), pick_target(), pick_full());
      end
    end
  endtask

  initial begin
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_op           = sramp_pkg::OP_TICK;
    in_target_speed = '0;
    in_max_speed    = '0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_wdata       = '0;
    beats_sent      = 0;
    settings_count  = 0;
    idle_on         = 1'b1;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // reset values: long interval holds the speed
    send_beat(sramp_pkg::OP_SET, SB'(5), (SB-1)'(10));
    send_tick();
    send_beat(sramp_pkg::OP_RELEASE, '0, '0);

    load_regs(3, 5, 1, 100, 900);
    send_beat(sramp_pkg::OP_SET, SB'(10), (SB-1)'(20));
    repeat (2) send_tick();
    send_beat(sramp_pkg::OP_SET, SPD_MOST_NEG, '0);
    repeat (4) send_tick();
    send_beat(sramp_pkg::OP_ESTOP, SPD_TOP, FULL_TOP);
    send_tick();
    send_beat(sramp_pkg::OP_SET, SB'(500), FULL_TOP);
    send_beat(sramp_pkg::OP_RELEASE, '0, '0);
    repeat (2) send_tick();
    send_beat(sramp_pkg::OP_SET, '0, (SB-1)'(7));
    send_beat(sramp_pkg::OP_SET, SPD_TOP, FULL_TOP);
    repeat (3) send_tick();
    send_beat(sramp_pkg::OP_SET, -SPD_TOP, (SB-1)'(1));
    repeat (2) send_tick();

    load_regs(1, 1, 0, 0, CW'(PWR_TOP));
    run_traffic(RAND_PHASE_BEATS);
    load_regs(CW'(STEP_TOP), CW'(STEP_TOP), 0, 0, CW'(PWR_TOP));
    run_traffic(RAND_PHASE_BEATS);
    load_regs(CW'($urandom_range(1, 60)), CW'($urandom_range(1, 60)), 1,
              CW'($urandom_range(0, 1023)), CW'($urandom_range(0, 1023)));
    run_traffic(RAND_PHASE_BEATS);
    load_regs(0, 5, 2, 200, 800);
    run_traffic(RAND_PHASE_BEATS);
    load_regs(7, 0, 0, CW'(PWR_TOP), 0);
    run_traffic(RAND_PHASE_BEATS);
    load_regs(CW'($urandom), CW'($urandom), CW'($urandom_range(0, 3)), CW'($urandom),
              CW'($urandom));
    run_traffic(RAND_PHASE_BEATS);

    // hold speed at zero over a run of ticks, then a full-scale interval holds the speed
    idle_on = 1'b0;
    send_beat(sramp_pkg::OP_RELEASE, '0, '0);
    send_beat(sramp_pkg::OP_SET, '0, '0);
    repeat (HOLD_TICKS) send_tick();
    load_regs(5, 5, CW'(IVL_TOP), 0, CW'(PWR_TOP));
    send_beat(sramp_pkg::OP_SET, SB'(9), (SB-1)'(30));
    send_tick();

    load_regs(12, 30, 3, 500, 500);
    run_traffic(RAND_PHASE_BEATS);
    load_regs(9, 4, 2, 0, CW'(PWR_TOP));
    run_traffic(RAND_PHASE_BEATS);

    in_valid <= 1'b0;
    while (pending_count != 0) @(negedge clk);
    repeat (QUIET) @(negedge clk);
    $display("%0d input beats, %0d results checked over %0d register settings",
             beats_sent, result_count, settings_count);
    $display("covered e-stop windows, zero-goal stops, zero steps, flat and reversed spans");
    if (fail_count == 0) begin
      $display("speed_ramp_with_estop: match");
    end else begin
      $display("speed_ramp_with_estop: mismatch");
    end
    $finish;
  end

endmodule

>>> sim.f
design/sramp_pkg.sv
design/sramp_front.sv
design/sramp_queue.sv
design/sramp_pmap.sv
design/sramp_back.sv
design/speed_ramp_with_estop.sv
tb/speed_ramp_checker.sv
tb/tb_speed_ramp_with_estop.sv
